// ----- sv/page_frame_bitmap_allocator_assert.svh -----
// Assertion macros for the page frame bitmap allocator.
// Taken in by the modules that check their own logic; no other dependencies.
`ifndef PAGE_FRAME_BITMAP_ALLOCATOR_ASSERT_SVH
`define PAGE_FRAME_BITMAP_ALLOCATOR_ASSERT_SVH

// clocked property with asynchronous active-low reset
`define PFBA_CLK_PROP(clk, rstn, prop) @(posedge clk) disable iff (!rstn) prop

`define PFBA_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (`PFBA_CLK_PROP(clk, rstn, prop)) else $error(msg);

`endif

// ----- sv/pfba_pkg.sv -----
// Types and constants of the page frame bitmap allocator.
// Used by the controller, the datapath and the top level; no dependencies.
package pfba_pkg;

  localparam int FRAME_W    = 21;   // frame numbers up to 2^20 inclusive
  localparam int ADDR_W     = 32;
  localparam int PAGE_SHIFT = 12;
  localparam int FREE_W     = 21;
  localparam int REQ_W      = 3;
  localparam int KIND_W     = 2;
  localparam int LOWMEM_MSB = 20;   // 1 MiB boundary bit

  typedef enum logic [REQ_W-1:0] {
    REQ_CLEAR  = 3'd0,
    REQ_REGION = 3'd1,
    REQ_FINISH = 3'd2,
    REQ_ALLOC  = 3'd3,
    REQ_FREE   = 3'd4
  } req_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_AVAIL = 2'd0,
    KIND_RSVD  = 2'd1
  } kind_e;

  typedef enum logic [3:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_DECODE,
    ST_CLEAR,
    ST_MRK_RD,
    ST_MRK_WR,
    ST_AL_RD,
    ST_AL_CHK,
    ST_FR_RD,
    ST_FR_WR,
    ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    ADDR_SWEEP,
    ADDR_MARK,
    ADDR_SCAN,
    ADDR_FREE
  } addr_sel_e;

  typedef struct packed {
    logic      load_req;
    logic      sweep_start;
    logic      sweep_step;
    logic      mark_load;
    logic      mark_step;
    logic      set_init;
    logic      alloc_load;
    logic      alloc_next;
    logic      alloc_take;
    logic      free_take;
    logic      rd_en;
    logic      res_clear;
    logic      out_load;
    addr_sel_e addr_sel;
  } cmd_t;

  typedef struct packed {
    logic [REQ_W-1:0] req;
    logic             sweep_last;
    logic             reg_go;
    logic             mark_more;
    logic             cnt_zero;
    logic             free_ok;
    logic             word_full;
    logic             scan_last;
    logic             out_busy;
  } sts_t;

endpackage

// ----- sv/page_frame_bitmap_allocator.sv -----
// Each request is decoded and then served: a region is marked word by word, an allocate
// scans word by word from the lowest word that may hold a free frame, a free reads its
// word and clears the frame's bit (skipped when the frame is out of range), a clear
// sweeps every map word; finish, unused codes and skipped regions go to the result.
// One request at a time. A result held by the receiver stalls the block. Reset clears
// the map by a sweep of every map word, during which no request is taken.
module page_frame_bitmap_allocator #(
  parameter int NUM_FRAMES = 1048576,
  parameter int WORD_BITS  = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [159:0] s_axis_tdata,  // region_base, region_length, frame_address
  input  logic [4:0]   s_axis_tuser,  // req_type, region_kind
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [55:0]  m_axis_tdata,  // alloc_address, free_frames, is_initialized, pad
  output logic [0:0]   m_axis_tuser   // found
);

  pfba_pkg::cmd_t cmd;
  pfba_pkg::sts_t sts;

  logic [pfba_pkg::ADDR_W-1:0] o_addr;
  logic                        o_found;
  logic [pfba_pkg::FREE_W-1:0] o_free;
  logic                        o_init;

  pfba_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  pfba_dp #(
    .NUM_FRAMES(NUM_FRAMES),
    .WORD_BITS (WORD_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .in_req_i   (s_axis_tuser[2:0]),
    .in_base_i  (s_axis_tdata[63:0]),
    .in_len_i   (s_axis_tdata[127:64]),
    .in_kind_i  (s_axis_tuser[4:3]),
    .in_faddr_i (s_axis_tdata[159:128]),
    .out_ready_i(m_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .out_addr_o (o_addr),
    .out_found_o(o_found),
    .out_free_o (o_free),
    .out_init_o (o_init)
  );

  assign m_axis_tdata = {2'b00, o_init, o_free, o_addr};
  assign m_axis_tuser = o_found;

endmodule

// ----- sv/pfba_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pfba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32768
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/pfba_ctrl.sv -----
// Controller state machine of the page frame bitmap allocator.
// Depends on pfba_pkg; drives the datapath by command and reads its status.
module pfba_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  pfba_pkg::sts_t sts_i,
  output pfba_pkg::cmd_t cmd_o
);

  pfba_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pfba_pkg::ST_SWEEP;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      pfba_pkg::ST_SWEEP, pfba_pkg::ST_CLEAR: begin
        cmd_o.sweep_step = 1'b1;
        cmd_o.addr_sel   = pfba_pkg::ADDR_SWEEP;
        if (sts_i.sweep_last) begin
          state_d = (state_q == pfba_pkg::ST_SWEEP) ? pfba_pkg::ST_IDLE : pfba_pkg::ST_DONE;
        end
      end
      pfba_pkg::ST_IDLE: begin
        in_ready_o     = 1'b1;
        cmd_o.load_req = in_valid_i;
        if (in_valid_i) begin
          state_d = pfba_pkg::ST_DECODE;
        end
      end
      pfba_pkg::ST_DECODE: begin
        cmd_o.res_clear = 1'b1;
        state_d         = pfba_pkg::ST_DONE;
        case (sts_i.req)
          pfba_pkg::REQ_CLEAR: begin
            cmd_o.sweep_start = 1'b1;
            state_d           = pfba_pkg::ST_CLEAR;
          end
          pfba_pkg::REQ_REGION: begin
            if (sts_i.reg_go) begin
              cmd_o.mark_load = 1'b1;
              state_d         = pfba_pkg::ST_MRK_RD;
            end
          end
          pfba_pkg::REQ_FINISH: begin
            cmd_o.set_init = 1'b1;
          end
          pfba_pkg::REQ_ALLOC: begin
            if (!sts_i.cnt_zero) begin
              cmd_o.alloc_load = 1'b1;
              state_d          = pfba_pkg::ST_AL_RD;
            end
          end
          pfba_pkg::REQ_FREE: begin
            if (sts_i.free_ok) begin
              state_d = pfba_pkg::ST_FR_RD;
            end
          end
          default: begin
            state_d = pfba_pkg::ST_DONE;
          end
        endcase
      end
      pfba_pkg::ST_MRK_RD: begin
        cmd_o.addr_sel = pfba_pkg::ADDR_MARK;
        if (sts_i.mark_more) begin
          cmd_o.rd_en = 1'b1;
          state_d     = pfba_pkg::ST_MRK_WR;
        end else begin
          state_d = pfba_pkg::ST_DONE;
        end
      end
      pfba_pkg::ST_MRK_WR: begin
        cmd_o.addr_sel  = pfba_pkg::ADDR_MARK;
        cmd_o.mark_step = 1'b1;
        state_d         = pfba_pkg::ST_MRK_RD;
      end
      pfba_pkg::ST_AL_RD: begin
        cmd_o.addr_sel = pfba_pkg::ADDR_SCAN;
        cmd_o.rd_en    = 1'b1;
        state_d        = pfba_pkg::ST_AL_CHK;
      end
      pfba_pkg::ST_AL_CHK: begin
        cmd_o.addr_sel = pfba_pkg::ADDR_SCAN;
        if (!sts_i.word_full) begin
          cmd_o.alloc_take = 1'b1;
          state_d          = pfba_pkg::ST_DONE;
        end else if (sts_i.scan_last) begin
          state_d = pfba_pkg::ST_DONE;
        end else begin
          cmd_o.alloc_next = 1'b1;
          state_d          = pfba_pkg::ST_AL_RD;
        end
      end
      pfba_pkg::ST_FR_RD: begin
        cmd_o.addr_sel = pfba_pkg::ADDR_FREE;
        cmd_o.rd_en    = 1'b1;
        state_d        = pfba_pkg::ST_FR_WR;
      end
      pfba_pkg::ST_FR_WR: begin
        cmd_o.addr_sel  = pfba_pkg::ADDR_FREE;
        cmd_o.free_take = 1'b1;
        state_d         = pfba_pkg::ST_DONE;
      end
      pfba_pkg::ST_DONE: begin
        if (!sts_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = pfba_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = pfba_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ----- sv/pfba_dp.sv -----
// Datapath of the page frame bitmap allocator: request registers, map RAM,
// mark/scan/free word logic, counters and result register. Uses pfba_pkg, pfba_ram.
`include "page_frame_bitmap_allocator_assert.svh"
module pfba_dp #(
  parameter int NUM_FRAMES = 1048576,
  parameter int WORD_BITS  = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  pfba_pkg::cmd_t                 cmd_i,
  output pfba_pkg::sts_t                 sts_o,
  input  logic [pfba_pkg::REQ_W-1:0]     in_req_i,
  input  logic [63:0]                    in_base_i,
  input  logic [63:0]                    in_len_i,
  input  logic [pfba_pkg::KIND_W-1:0]    in_kind_i,
  input  logic [pfba_pkg::ADDR_W-1:0]    in_faddr_i,
  input  logic                           out_ready_i,
  output logic                           out_valid_o,
  output logic [pfba_pkg::ADDR_W-1:0]    out_addr_o,
  output logic                           out_found_o,
  output logic [pfba_pkg::FREE_W-1:0]    out_free_o,
  output logic                           out_init_o
);

  localparam int MAP_WORDS = (NUM_FRAMES + WORD_BITS - 1) / WORD_BITS;
  localparam int WIDX_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int BIT_W     = $clog2(WORD_BITS);
  localparam int CNT_W     = $clog2(NUM_FRAMES + 1);
  localparam int FW        = pfba_pkg::FRAME_W;
  localparam logic [FW-1:0]     NUM_F     = FW'(NUM_FRAMES);
  localparam logic [WIDX_W-1:0] LAST_WORD = WIDX_W'(MAP_WORDS - 1);

  // request registers
  logic [pfba_pkg::REQ_W-1:0]  req_q;
  logic [63:0]                 base_q, len_q;
  logic [pfba_pkg::KIND_W-1:0] kind_q;
  logic [FW-1:0]               fidx_q;

  // walk state
  logic [WIDX_W-1:0] sweep_q, scan_q, hint_q;
  logic [FW-1:0]     f_q, last_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              init_q;
  logic [pfba_pkg::ADDR_W-1:0] res_addr_q;
  logic              found_q;

  // result register
  logic                        ov_q;
  logic [pfba_pkg::ADDR_W-1:0] o_addr_q;
  logic                        o_found_q;
  logic [pfba_pkg::FREE_W-1:0] o_free_q;
  logic                        o_init_q;

  logic                 we;
  logic [WIDX_W-1:0]    ram_addr;
  logic [WORD_BITS-1:0] wdata, rdata;

  // region decode
  logic [32:0] room;
  logic        len_ok, kind_mark;
  logic [FW-1:0] first_f, end_f, last_f;

  // word logic
  logic [WIDX_W-1:0]    mark_w, free_w;
  logic [FW-1:0]        mark_base, scan_base;
  logic [WORD_BITS-1:0] mark_mask, fresh, eff, take_bit, free_bit;
  logic [BIT_W:0]       pop;
  logic [BIT_W-1:0]     zpos, free_b;
  logic                 bit_set;

  always_comb begin
    room      = 33'h1_0000_0000 - {1'b0, base_q[31:0]};
    len_ok    = (base_q[63:32] == '0) && (len_q[63:33] == '0) && (len_q[32:0] <= room);
    kind_mark = (kind_q == pfba_pkg::KIND_RSVD) ||
                ((kind_q == pfba_pkg::KIND_AVAIL) && (base_q[31:pfba_pkg::LOWMEM_MSB] == '0));
    first_f   = FW'(base_q[31:pfba_pkg::PAGE_SHIFT]);
    end_f     = first_f + len_q[32:pfba_pkg::PAGE_SHIFT];
    last_f    = (end_f > NUM_F) ? NUM_F : end_f;
  end

  always_comb begin
    mark_w    = f_q[BIT_W +: WIDX_W];
    mark_base = FW'({mark_w, {BIT_W{1'b0}}});
    scan_base = FW'({scan_q, {BIT_W{1'b0}}});
    free_w    = fidx_q[BIT_W +: WIDX_W];
    free_b    = fidx_q[BIT_W-1:0];
    for (int i = 0; i < WORD_BITS; i++) begin
      mark_mask[i] = ((mark_base + FW'(i)) >= f_q) && ((mark_base + FW'(i)) < last_q);
      eff[i]       = rdata[i] | ((scan_base + FW'(i)) >= NUM_F);
    end
    fresh = mark_mask & ~rdata;
    pop   = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      pop = pop + (BIT_W+1)'(fresh[i]);
    end
    zpos = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!eff[i]) begin
        zpos = BIT_W'(i);
      end
    end
    take_bit = '0;
    take_bit[zpos] = 1'b1;
    free_bit = '0;
    free_bit[free_b] = 1'b1;
    bit_set  = rdata[free_b];
  end

  always_comb begin
    case (cmd_i.addr_sel)
      pfba_pkg::ADDR_SWEEP: ram_addr = sweep_q;
      pfba_pkg::ADDR_MARK:  ram_addr = mark_w;
      pfba_pkg::ADDR_SCAN:  ram_addr = scan_q;
      pfba_pkg::ADDR_FREE:  ram_addr = free_w;
      default:              ram_addr = sweep_q;
    endcase
    we = cmd_i.sweep_step | cmd_i.mark_step | cmd_i.alloc_take |
         (cmd_i.free_take & bit_set);
    if (cmd_i.mark_step) begin
      wdata = rdata | mark_mask;
    end else if (cmd_i.alloc_take) begin
      wdata = rdata | take_bit;
    end else if (cmd_i.free_take) begin
      wdata = rdata & ~free_bit;
    end else begin
      wdata = '0;
    end
  end

  pfba_ram #(
    .WIDTH(WORD_BITS),
    .DEPTH(MAP_WORDS)
  ) u_map (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(ram_addr),
    .wdata_i(wdata),
    .re_i   (cmd_i.rd_en),
    .raddr_i(ram_addr),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      req_q  <= in_req_i;
      base_q <= in_base_i;
      len_q  <= in_len_i;
      kind_q <= in_kind_i;
      fidx_q <= FW'(in_faddr_i[pfba_pkg::ADDR_W-1:pfba_pkg::PAGE_SHIFT]);
    end
    if (cmd_i.mark_load) begin
      f_q    <= first_f;
      last_q <= last_f;
    end else if (cmd_i.mark_step) begin
      f_q <= mark_base + FW'(WORD_BITS);
    end
    if (cmd_i.alloc_load) begin
      scan_q <= hint_q;
    end else if (cmd_i.alloc_next) begin
      scan_q <= scan_q + 1'b1;
    end
    if (cmd_i.res_clear) begin
      res_addr_q <= '0;
      found_q    <= 1'b0;
    end else if (cmd_i.alloc_take) begin
      res_addr_q <= pfba_pkg::ADDR_W'({scan_q, zpos, {pfba_pkg::PAGE_SHIFT{1'b0}}});
      found_q    <= 1'b1;
    end
    if (cmd_i.out_load) begin
      o_addr_q  <= res_addr_q;
      o_found_q <= found_q;
      o_free_q  <= pfba_pkg::FREE_W'(cnt_q);
      o_init_q  <= init_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_q <= '0;
      hint_q  <= '0;
      cnt_q   <= CNT_W'(NUM_FRAMES);
      init_q  <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      if (cmd_i.sweep_start) begin
        sweep_q <= '0;
        hint_q  <= '0;
        cnt_q   <= CNT_W'(NUM_FRAMES);
      end else begin
        if (cmd_i.sweep_step) begin
          sweep_q <= (sweep_q == LAST_WORD) ? '0 : sweep_q + 1'b1;
        end
        if (cmd_i.mark_step) begin
          cnt_q <= cnt_q - CNT_W'(pop);
        end else if (cmd_i.alloc_take) begin
          cnt_q  <= cnt_q - 1'b1;
          hint_q <= scan_q;
        end else if (cmd_i.free_take && bit_set) begin
          cnt_q <= cnt_q + 1'b1;
          if (free_w < hint_q) begin
            hint_q <= free_w;
          end
        end
      end
      if (cmd_i.set_init) begin
        init_q <= 1'b1;
      end
      if (cmd_i.out_load) begin
        ov_q <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_comb begin
    sts_o.req        = req_q;
    sts_o.sweep_last = (sweep_q == LAST_WORD);
    sts_o.reg_go     = len_ok && kind_mark;
    sts_o.mark_more  = (f_q < last_q);
    sts_o.cnt_zero   = (cnt_q == '0);
    sts_o.free_ok    = (fidx_q < NUM_F);
    sts_o.word_full  = &eff;
    sts_o.scan_last  = (scan_q == LAST_WORD);
    sts_o.out_busy   = ov_q & ~out_ready_i;
  end

  assign out_valid_o = ov_q;
  assign out_addr_o  = o_addr_q;
  assign out_found_o = o_found_q;
  assign out_free_o  = o_free_q;
  assign out_init_o  = o_init_q;

  `PFBA_ASSERT(a_cnt_range, clk_i, rst_ni, cnt_q <= CNT_W'(NUM_FRAMES), "free count above frame total")
  `PFBA_ASSERT(a_alloc_dec, clk_i, rst_ni, cmd_i.alloc_take |=> (cnt_q == $past(cnt_q) - 1'b1), "allocate did not take one frame")
  `PFBA_ASSERT(a_found_rng, clk_i, rst_ni, found_q |-> (FW'(res_addr_q[pfba_pkg::ADDR_W-1:pfba_pkg::PAGE_SHIFT]) < NUM_F), "allocated frame out of range")

endmodule

// ----- bench/tb_page_frame_bitmap_allocator.sv -----
// Self-checking bench for page_frame_bitmap_allocator: directed and random requests
// against a behavioural frame map held in a small scoreboard class.
// Depends on pfba_pkg and the allocator RTL only.
`timescale 1ns / 1ps

module tb_page_frame_bitmap_allocator;

  localparam int NFRAMES = 1048576;
  localparam int NWORDS  = NFRAMES / 32;

  typedef struct packed {
    logic [31:0] addr;
    logic        found;
    logic [20:0] free_cnt;
    logic        init;
  } status_t;

  class frame_map_sb;
    bit [31:0]   used_words[];
    int unsigned free_cnt;
    bit          init;
    int unsigned scan_from;   // no free frame below this word
    status_t     pending_q[$];
    int unsigned n_err;
    int unsigned n_seen;

    function new();
      used_words = new[NWORDS];
      free_cnt   = NFRAMES;
      scan_from  = 0;
    endfunction

    function void wipe();
      foreach (used_words[i]) used_words[i] = '0;
      free_cnt  = NFRAMES;
      scan_from = 0;
    endfunction

    function void mark_region(logic [63:0] base, logic [63:0] len, logic [1:0] kind);
      logic [64:0] top;
      longint unsigned f, last;
      top = {1'b0, base} + {1'b0, len};
      if (top > 65'h1_0000_0000) return;
      if (kind == pfba_pkg::KIND_RSVD ||
          (kind == pfba_pkg::KIND_AVAIL && base < 64'h0010_0000)) begin
        f    = base >> pfba_pkg::PAGE_SHIFT;
        last = f + (len >> pfba_pkg::PAGE_SHIFT);
        if (last > NFRAMES) last = NFRAMES;
        for (; f < last; f++) begin
          if (!used_words[f >> 5][f & 31]) begin
            used_words[f >> 5][f & 31] = 1'b1;
            free_cnt--;
          end
        end
      end
    endfunction

    // Predict the status for an accepted request; returns the expectation.
    function status_t note_request(logic [4:0] user, logic [159:0] data);
      status_t exp;
      int unsigned f;
      exp = '0;
      case (user[2:0])
        pfba_pkg::REQ_CLEAR:  wipe();
        pfba_pkg::REQ_REGION: mark_region(data[63:0], data[127:64], user[4:3]);
        pfba_pkg::REQ_FINISH: init = 1'b1;
        pfba_pkg::REQ_ALLOC: begin
          while (scan_from < NWORDS && used_words[scan_from] == '1) scan_from++;
          if (scan_from < NWORDS) begin
            for (int b = 31; b >= 0; b--)
              if (!used_words[scan_from][b]) f = scan_from * 32 + b;
            used_words[scan_from][f & 31] = 1'b1;
            free_cnt--;
            exp.addr  = f << pfba_pkg::PAGE_SHIFT;
            exp.found = 1'b1;
          end
        end
        pfba_pkg::REQ_FREE: begin
          f = 32'(data[159:140]);
          if (used_words[f >> 5][f & 31]) begin
            used_words[f >> 5][f & 31] = 1'b0;
            free_cnt++;
            if ((f >> 5) < scan_from) scan_from = f >> 5;
          end
        end
        default: ;
      endcase
      exp.free_cnt = 21'(free_cnt);
      exp.init     = init;
      pending_q.push_back(exp);
      return exp;
    endfunction

    function void check_result(status_t act);
      status_t exp;
      n_seen++;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, act);
        n_err++;
        return;
      end
      exp = pending_q.pop_front();
      if (exp.addr !== act.addr) begin
        $display("%0t: alloc_address exp %h got %h", $time, exp.addr, act.addr);
        n_err++;
      end
      if (exp.found !== act.found) begin
        $display("%0t: found exp %b got %b", $time, exp.found, act.found);
        n_err++;
      end
      if (exp.free_cnt !== act.free_cnt) begin
        $display("%0t: free_frames exp %0d got %0d", $time, exp.free_cnt, act.free_cnt);
        n_err++;
      end
      if (exp.init !== act.init) begin
        $display("%0t: is_initialized exp %b got %b", $time, exp.init, act.init);
        n_err++;
      end
    endfunction
  endclass

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [159:0] s_axis_tdata = '0;
  logic [4:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [55:0]  m_axis_tdata;
  logic [0:0]   m_axis_tuser;

  frame_map_sb sb = new();
  bit          calm;       // no idling on either side
  bit          hold_req;   // receiver holds off for a long stretch
  int unsigned n_sent;
  int unsigned n_clear;
  int unsigned n_alloc_hit;
  logic [31:0] taken_q[$];

  page_frame_bitmap_allocator u_top (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic int unsigned gap_len();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // receiver side
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (400) @(negedge clk_i);
        hold_req = 1'b0;
      end else if (calm) begin
        m_axis_tready <= 1'b1;
      end else begin
        if ($urandom_range(0, 99) < 3) begin
          m_axis_tready <= 1'b0;
          repeat ($urandom_range(10, 40)) @(negedge clk_i);
        end else begin
          m_axis_tready <= ($urandom_range(0, 99) < 70);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_result({m_axis_tdata[31:0], m_axis_tuser[0], m_axis_tdata[52:32],
                       m_axis_tdata[53]});
  end

  task automatic send_req(logic [4:0] user, logic [159:0] data);
    status_t exp;
    int unsigned g;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= user;
    s_axis_tdata  <= data;
    do @(posedge clk_i); while (!s_axis_tready);
    exp = sb.note_request(user, data);
    n_sent++;
    if (user[2:0] == pfba_pkg::REQ_ALLOC && exp.found) begin
      taken_q.push_back(exp.addr);
      n_alloc_hit++;
    end
    if (user[2:0] == pfba_pkg::REQ_CLEAR) n_clear++;
    g = gap_len();
    if (g > 0) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat (g - 1) @(negedge clk_i);
    end
  endtask

  task automatic send_simple(pfba_pkg::req_e req, logic [31:0] fa = 32'h0);
    send_req({2'b00, req}, {fa, 128'h0});
  endtask

  task automatic send_region(logic [63:0] base, logic [63:0] len, logic [1:0] kind);
    send_req({kind, pfba_pkg::REQ_REGION}, {32'h0, len, base});
  endtask

  // sender stops offering until every outstanding status is back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    wait (sb.pending_q.size() == 0);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic rand_item();
    int unsigned r;
    logic [159:0] d;
    logic [31:0]  fa;
    d = {$urandom, $urandom, $urandom, $urandom, $urandom};
    r = $urandom_range(0, 99);
    if (r < 35) begin
      send_req({d[1:0], pfba_pkg::REQ_ALLOC}, d);
    end else if (r < 65) begin
      if (taken_q.size() > 0 && $urandom_range(0, 99) < 80) begin
        fa = taken_q[$urandom_range(0, taken_q.size() - 1)];
        fa[11:0] = 12'($urandom);
      end else begin
        fa = $urandom;
      end
      d[159:128] = fa;
      send_req({d[1:0], pfba_pkg::REQ_FREE}, d);
    end else if (r < 86) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        d[63:0]   = 64'($urandom_range(0, 32'h0100_0000));
        d[127:64] = 64'($urandom_range(0, 32'h0004_0000));
      end else if (r < 95) begin
        d[63:32]  = (r & 1) ? 32'h0 : d[63:32];
        d[127:64] = (r & 1) ? {32'h0, 4'h0, d[91:64]} : d[127:64];
      end else begin
        d[63:0]   = {32'h0, d[31:0]};
        d[127:64] = 64'($urandom_range(0, 32'h0400_0000));
      end
      send_req({d[1:0], pfba_pkg::REQ_REGION}, d);
    end else if (r < 91) begin
      send_req({d[1:0], pfba_pkg::REQ_FINISH}, d);
    end else if (r < 92 && n_clear < 8) begin
      send_req({d[1:0], pfba_pkg::REQ_CLEAR}, d);
    end else begin
      // unused codes and stray kinds
      send_req({d[1:0], 3'($urandom_range(5, 7))}, d);
    end
  endtask

  initial begin
    calm = 1'b1;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed part
    send_simple(pfba_pkg::REQ_ALLOC);
    send_simple(pfba_pkg::REQ_ALLOC);
    send_simple(pfba_pkg::REQ_FREE, 32'h0000_0fff);
    send_simple(pfba_pkg::REQ_FREE, 32'h0000_0fff);
    send_region(64'h0, 64'h0000_5fff, pfba_pkg::KIND_AVAIL);
    send_region(64'h0020_0000, 64'h3000, pfba_pkg::KIND_AVAIL);
    send_region(64'h0020_0000, 64'h3000, pfba_pkg::KIND_RSVD);
    send_region(64'h0030_0000, 64'h3000, 2'd2);
    send_region(64'h0030_0000, 64'h3000, 2'd3);
    send_region(64'hffff_f000, 64'h1000, pfba_pkg::KIND_RSVD);
    send_region(64'hffff_f000, 64'h1001, pfba_pkg::KIND_RSVD);
    send_region(64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff, pfba_pkg::KIND_RSVD);
    send_region(64'h1_0000_0000, 64'h0, pfba_pkg::KIND_RSVD);
    send_req({2'b11, 3'd5}, '1);
    send_req({2'b00, 3'd6}, '0);
    send_req({2'b10, 3'd7}, '1);
    send_simple(pfba_pkg::REQ_FINISH);
    send_region(64'h0, 64'h1_0000_0000, pfba_pkg::KIND_RSVD);
    send_simple(pfba_pkg::REQ_ALLOC);
    send_simple(pfba_pkg::REQ_FREE, 32'hffff_ffff);
    send_simple(pfba_pkg::REQ_ALLOC);
    send_simple(pfba_pkg::REQ_FREE, 32'hffff_f000);
    send_simple(pfba_pkg::REQ_CLEAR);
    send_simple(pfba_pkg::REQ_ALLOC);
    calm = 1'b0;

    // random part
    for (int i = 0; i < 1800; i++) begin
      if (i == 200 || i == 1400) calm = 1'b1;
      if (i == 350 || i == 1550) calm = 1'b0;
      if (i == 600 || i == 1100) hold_req = 1'b1;
      if (i == 900) drain();
      rand_item();
    end

    drain();
    repeat (200) @(posedge clk_i);
    $display("%0d requests sent (%0d clears, %0d frames allocated), %0d statuses checked",
             n_sent, n_clear, n_alloc_hit, sb.n_seen);
    $display("Covered region marking, allocate on full and sparse maps, frees, odd codes.");
    if (sb.n_err == 0 && sb.pending_q.size() == 0) begin
      $display("tb_page_frame_bitmap_allocator: PASS");
    end else begin
      $display("tb_page_frame_bitmap_allocator: FAIL");
    end
    $finish;
  end

  initial begin
    #60ms;
    $display("Timeout with %0d statuses outstanding", sb.pending_q.size());
    $display("tb_page_frame_bitmap_allocator: FAIL");
    $finish;
  end

endmodule
